@@ src/acid_pkg.sv @@
// Shared types and codes for the A-unit instruction decoder.
// Used by acid_decode and the top level; depends on nothing.
`default_nettype none

package acid_pkg;

  localparam int SLOT_W     = 41;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 7;
  localparam int IMM_W      = 22;

  // Major opcodes
  localparam logic [3:0] MAJ_ALU     = 4'h8;
  localparam logic [3:0] MAJ_ADDL    = 4'h9;
  localparam logic [3:0] MAJ_SHLADD  = 4'hA;
  localparam logic [3:0] MAJ_CMP_LT  = 4'hC;
  localparam logic [3:0] MAJ_CMP_LTU = 4'hD;
  localparam logic [3:0] MAJ_CMP_EQ  = 4'hE;

  // Major 8 x4 codes
  localparam logic [3:0] X4_ADD    = 4'h0;
  localparam logic [3:0] X4_SUB    = 4'h1;
  localparam logic [3:0] X4_AND    = 4'h3;
  localparam logic [3:0] X4_SHLADD = 4'h4;
  localparam logic [3:0] X4_XOR    = 4'h6;
  localparam logic [3:0] X4_LOGIMM = 4'hB;

  // Dense operation kinds
  localparam logic [4:0] K_ADD     = 5'd0;
  localparam logic [4:0] K_AND     = 5'd2;
  localparam logic [4:0] K_IMM_OFS = 5'd6;
  localparam logic [4:0] K_SHLADD  = 5'd12;
  localparam logic [4:0] K_CMP     = 5'd13;
  localparam logic [4:0] K_CMP4    = 5'd20;

  // Compare relation offsets
  localparam logic [4:0] C_EQ  = 5'd0;
  localparam logic [4:0] C_NE  = 5'd1;
  localparam logic [4:0] C_LT  = 5'd2;
  localparam logic [4:0] C_LTU = 5'd3;
  localparam logic [4:0] C_GT  = 5'd4;
  localparam logic [4:0] C_LE  = 5'd5;
  localparam logic [4:0] C_GE  = 5'd6;

  // Completers
  localparam logic [2:0] CMPL_NONE = 3'd0;
  localparam logic [2:0] CMPL_UNC  = 3'd1;
  localparam logic [2:0] CMPL_AND  = 3'd2;

  typedef struct packed {
    logic              valid_res;
    logic [4:0]        kind;
    logic [2:0]        completer;
    logic [5:0]        qual_pred;
    logic [6:0]        dest_index;
    logic [6:0]        src_a;
    logic [6:0]        src_b;
    logic [5:0]        pred_two;
    logic              has_imm;
    logic [IMM_W-1:0]  imm;
  } dec_t;

endpackage

`default_nettype wire

@@ src/alu_compare_instruction_decoder.sv @@
// Top level of the A-unit instruction decoder: slot register, decode, result register.
// Depends on acid_pkg and acid_decode.
//
//  channel | dir | tdata                  | tuser
//  in_     | in  | slot [40:0], zero above | -
//  out_    | out | decoded fields, 58 bits | valid_res, kind, has_imm
//
// A beat passes through the slot register, then the decode into the result
// register. One beat per cycle is sustained while out_tready is not held low;
// throughput is set by the single decode stage.
// Reset (rst_n low, synchronous) empties both stages.
// A stall on out_tready holds the result; the slot register still takes a
// beat while it is empty or the result register is empty or being drained.
`default_nettype none

module alu_compare_instruction_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [acid_pkg::IN_DATA_W-1:0]  in_tdata,   // [40:0] raw_word
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [2:0] completer, [8:3] qual_pred, [15:9] dest_index, [22:16] src_a,
  // [29:23] src_b, [35:30] pred_two, [57:36] imm
  output logic [acid_pkg::OUT_DATA_W-1:0]      out_tdata,
  // [0] valid_res, [5:1] kind, [6] has_imm
  output logic [acid_pkg::OUT_USER_W-1:0]      out_tuser
);

  logic                          slot_v_r, slot_v_nxt;
  logic [acid_pkg::SLOT_W-1:0]   slot_r;
  logic                          res_v_r, res_v_nxt;
  acid_pkg::dec_t                res_r;
  acid_pkg::dec_t                dec;
  logic                          res_ld, slot_ld;

  // advance the decode stage when the result register is empty or draining
  assign res_ld    = !res_v_r || out_tready;
  assign in_tready = !slot_v_r || res_ld;
  assign slot_ld   = in_tvalid && in_tready;

  assign slot_v_nxt = slot_ld ? 1'b1 : (res_ld ? 1'b0 : slot_v_r);
  assign res_v_nxt  = res_ld ? slot_v_r : res_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
      res_v_r  <= 1'b0;
    end else begin
      slot_v_r <= slot_v_nxt;
      res_v_r  <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_ld) begin
      slot_r <= in_tdata[acid_pkg::SLOT_W-1:0];
    end
    if (res_ld && slot_v_r) begin
      res_r <= dec;
    end
  end

  acid_decode u_decode (
    .raw_word (slot_r),
    .dec      (dec)
  );

  assign out_tvalid = res_v_r;
  assign out_tdata  = {6'b0, res_r.imm, res_r.pred_two, res_r.src_b, res_r.src_a,
                       res_r.dest_index, res_r.qual_pred, res_r.completer};
  assign out_tuser  = {res_r.has_imm, res_r.kind, res_r.valid_res};

endmodule

`default_nettype wire

@@ src/acid_decode.sv @@
// Combinational decode of one 41-bit A-unit slot into a dec_t.
// Depends on acid_pkg for codes and the result struct.
`default_nettype none

module acid_decode (
  input  wire logic [40:0]   raw_word,
  output acid_pkg::dec_t     dec
);

  logic [5:0] qp;
  logic [6:0] r1, r2, r3;
  logic [1:0] x2a, x2b;
  logic [3:0] x4, major;
  logic       ve, s, c, ta;
  logic       base, immf, is32, imm8_zero;
  logic [acid_pkg::IMM_W-1:0] imm8, imm14, imm22;
  logic [4:0] off;
  acid_pkg::dec_t d;

  assign qp    = raw_word[5:0];
  assign r1    = raw_word[12:6];
  assign r2    = raw_word[19:13];
  assign r3    = raw_word[26:20];
  assign x2b   = raw_word[28:27];
  assign x4    = raw_word[32:29];
  assign ve    = raw_word[33];
  assign x2a   = raw_word[35:34];
  assign s     = raw_word[36];
  assign major = raw_word[40:37];
  assign c     = raw_word[12];
  assign ta    = raw_word[33];

  assign imm8  = {{14{s}}, s, r2};
  assign imm14 = {{8{s}}, s, raw_word[32:27], r2};
  assign imm22 = {s, raw_word[35:27], raw_word[26:22], r2};

  assign base      = (x2a == 2'd0) && !ve;
  assign immf      = x2a[1];
  assign is32      = x2a[0];
  assign imm8_zero = !s && (r2 == 7'd0);

  always_comb begin
    d            = '0;
    d.valid_res  = 1'b1;
    d.qual_pred  = qp;
    d.dest_index = r1;
    d.src_a      = r2;
    d.src_b      = r3;
    off          = acid_pkg::C_EQ;
    case (major)
      acid_pkg::MAJ_ALU: begin
        if (base && x4 == acid_pkg::X4_AND) begin
          d.kind = acid_pkg::K_AND + {3'b0, x2b};
        end else if (base && x4 == acid_pkg::X4_SHLADD) begin
          d.kind    = acid_pkg::K_SHLADD;
          d.has_imm = 1'b1;
          d.imm     = acid_pkg::IMM_W'(x2b) + 22'd1;
        end else if (base && x4 == acid_pkg::X4_LOGIMM) begin
          d.valid_res = (x2b != 2'd1);
          d.kind      = acid_pkg::K_IMM_OFS + acid_pkg::K_AND + {3'b0, x2b};
          d.src_a     = r3;
          d.src_b     = '0;
          d.has_imm   = 1'b1;
          d.imm       = imm8;
        end else if (x2a == 2'd2 && !ve) begin
          d.kind    = acid_pkg::K_IMM_OFS + acid_pkg::K_ADD;
          d.src_a   = r3;
          d.src_b   = '0;
          d.has_imm = 1'b1;
          d.imm     = imm14;
        end else begin
          if (x4 == acid_pkg::X4_ADD || x4 == acid_pkg::X4_SUB) begin
            d.kind = {1'b0, x4};
          end else if (x4 >= acid_pkg::X4_AND && x4 <= acid_pkg::X4_XOR) begin
            d.kind = {1'b0, x4} - 5'd1;
          end else begin
            d.valid_res = 1'b0;
          end
          if (immf) begin
            d.kind    = d.kind + acid_pkg::K_IMM_OFS;
            d.src_b   = '0;
            d.has_imm = 1'b1;
            d.imm     = is32 ? imm14 : imm8;
          end
        end
      end
      acid_pkg::MAJ_ADDL: begin
        d.kind    = acid_pkg::K_IMM_OFS + acid_pkg::K_ADD;
        d.src_a   = {5'b0, raw_word[21:20]};
        d.src_b   = '0;
        d.has_imm = 1'b1;
        d.imm     = imm22;
      end
      acid_pkg::MAJ_SHLADD: begin
        d.valid_res = (x4 == acid_pkg::X4_ADD);
        d.kind      = acid_pkg::K_SHLADD;
        d.has_imm   = 1'b1;
        d.imm       = acid_pkg::IMM_W'(x2a) + 22'd1;
      end
      acid_pkg::MAJ_CMP_LT, acid_pkg::MAJ_CMP_LTU, acid_pkg::MAJ_CMP_EQ: begin
        // Register compare against r0 with the sign bit set
        if (!immf && s && r2 == 7'd0) begin
          if (!ta) begin
            off = c ? acid_pkg::C_LE : acid_pkg::C_GT;
          end else begin
            off = c ? acid_pkg::C_LT : acid_pkg::C_GE;
          end
          d.completer = 3'(major - acid_pkg::MAJ_CMP_LT) + acid_pkg::CMPL_AND;
        end else if (ta) begin
          off         = c ? acid_pkg::C_NE : acid_pkg::C_EQ;
          d.completer = 3'(major - acid_pkg::MAJ_CMP_LT) + acid_pkg::CMPL_AND;
        end else begin
          if (major == acid_pkg::MAJ_CMP_LT) begin
            off = acid_pkg::C_LT;
          end else if (major == acid_pkg::MAJ_CMP_LTU) begin
            // unsigned less-than zero immediate turns into not-equal
            off = (immf && imm8_zero) ? acid_pkg::C_NE : acid_pkg::C_LTU;
          end else begin
            off = acid_pkg::C_EQ;
          end
          d.completer = c ? acid_pkg::CMPL_UNC : acid_pkg::CMPL_NONE;
        end
        d.kind       = (is32 ? acid_pkg::K_CMP4 : acid_pkg::K_CMP) + off;
        d.dest_index = {1'b0, raw_word[11:6]};
        d.pred_two   = raw_word[32:27];
        if (immf) begin
          d.has_imm = 1'b1;
          d.imm     = imm8;
        end
      end
      default: begin
        d.valid_res = 1'b0;
      end
    endcase
    if (!d.valid_res) begin
      d = '0;
    end
  end

  assign dec = d;

endmodule

`default_nettype wire

@@ src/acid_checker.sv @@
// Port-level checker for alu_compare_instruction_decoder, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module acid_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [6:0]  out_tuser
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // input backpressure only when both stages are full and the output stalls
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // rejected encodings carry all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 64'd0 && out_tuser == 7'd0)
    else $error("invalid encoding with nonzero fields");

  // immediate is zero when not meaningful, and kinds stay dense
  a_imm_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[6] || out_tdata[57:36] == 22'd0) && out_tuser[5:1] <= 5'd26)
    else $error("stray immediate or kind out of range");

endmodule

bind alu_compare_instruction_decoder acid_checker u_acid_checker (.*);

`default_nettype wire
